FILE: hw/rtl/mpst_pkg.sv
// Shared types and constants of the pointing-device state table.
package mpst_pkg;

    localparam int DEVICE_SLOTS = 8;
    localparam int BUTTON_COUNT = 5;
    localparam int MAX_RESULTS  = 8;
    localparam int BTN_W        = 5;
    localparam int ID_W         = 4;
    localparam int CNT_W        = 4;
    localparam int KEY_W        = 32;
    localparam int MOVE_W       = 32;
    localparam int WHEEL_W      = 16;
    localparam int S_DATA_W     = 128;
    localparam int S_USER_W     = 3;
    localparam int M_DATA_W     = 104;

    localparam logic [BTN_W-1:0] BUTTON_MASK = BTN_W'((1 << BUTTON_COUNT) - 1);
    localparam logic [CNT_W-1:0] CAP_RESET   = CNT_W'(8);
    localparam logic [CNT_W-1:0] CAP_LIMIT   = CNT_W'(MAX_RESULTS);

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_EVENT = 2'd0;
    localparam mode_t MODE_POLL  = 2'd1;
    localparam mode_t MODE_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_EVENT,
        OP_POLL,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic                      vld;
        op_t                       op;
        logic [KEY_W-1:0]          key;
        logic signed [MOVE_W-1:0]  mx;
        logic signed [MOVE_W-1:0]  my;
        logic [BTN_W-1:0]          down;
        logic [BTN_W-1:0]          up;
        logic signed [WHEEL_W-1:0] wheel;
        logic                      done;
        logic [CNT_W-1:0]          cnt;
        logic [CNT_W-1:0]          limit;
    } tok_t;

    typedef struct packed {
        logic                      emit;
        logic                      last;
        logic [ID_W-1:0]           id;
        logic signed [MOVE_W-1:0]  sx;
        logic signed [MOVE_W-1:0]  sy;
        logic signed [WHEEL_W-1:0] wheel;
        logic [BTN_W-1:0]          held;
        logic [BTN_W-1:0]          pressed;
        logic [BTN_W-1:0]          released;
    } rec_t;

endpackage

FILE: hw/rtl/mpst_cell.sv
// One slot of the device table: holds a device's state and passes the command word on.
module mpst_cell #(
    parameter int SLOT_IDX = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          stall,
    input  mpst_pkg::tok_t tok_i,
    input  logic          nxt_valid_i,
    output mpst_pkg::tok_t tok_o,
    output logic          valid_o,
    output mpst_pkg::rec_t rec_o
);
    import mpst_pkg::*;

    tok_t                      tok_reg;
    logic                      valid_reg;
    logic [KEY_W-1:0]          key_reg;
    logic signed [MOVE_W-1:0]  ax_reg;
    logic signed [MOVE_W-1:0]  ay_reg;
    logic signed [WHEEL_W-1:0] wheel_reg;
    logic [BTN_W-1:0]          held_reg;
    logic [BTN_W-1:0]          pr_reg;
    logic [BTN_W-1:0]          rl_reg;

    logic                      hit;
    logic                      act_evt;
    logic                      emit;
    logic signed [MOVE_W-1:0]  bx;
    logic signed [MOVE_W-1:0]  by;
    logic [BTN_W-1:0]          bh;
    logic [BTN_W-1:0]          bp;
    logic [BTN_W-1:0]          br;
    logic signed [MOVE_W:0]    sx_w;
    logic signed [MOVE_W:0]    sy_w;
    logic signed [MOVE_W-1:0]  ax_next;
    logic signed [MOVE_W-1:0]  ay_next;
    logic [BTN_W-1:0]          held_next;
    logic [BTN_W-1:0]          pr_next;
    logic [BTN_W-1:0]          rl_next;

    always_comb begin
        hit     = valid_reg && (key_reg == tok_reg.key);
        act_evt = tok_reg.vld && (tok_reg.op == OP_EVENT) && !tok_reg.done
                  && (hit || !valid_reg);
        bx = valid_reg ? ax_reg : '0;
        by = valid_reg ? ay_reg : '0;
        bh = valid_reg ? held_reg : '0;
        bp = valid_reg ? pr_reg : '0;
        br = valid_reg ? rl_reg : '0;

        sx_w = {bx[MOVE_W-1], bx} + {tok_reg.mx[MOVE_W-1], tok_reg.mx};
        sy_w = {by[MOVE_W-1], by} + {tok_reg.my[MOVE_W-1], tok_reg.my};
        if (sx_w[MOVE_W] != sx_w[MOVE_W-1]) begin
            ax_next = sx_w[MOVE_W] ? {1'b1, {(MOVE_W-1){1'b0}}} : {1'b0, {(MOVE_W-1){1'b1}}};
        end else begin
            ax_next = sx_w[MOVE_W-1:0];
        end
        if (sy_w[MOVE_W] != sy_w[MOVE_W-1]) begin
            ay_next = sy_w[MOVE_W] ? {1'b1, {(MOVE_W-1){1'b0}}} : {1'b0, {(MOVE_W-1){1'b1}}};
        end else begin
            ay_next = sy_w[MOVE_W-1:0];
        end

        held_next = (bh | (tok_reg.down & BUTTON_MASK)) & ~(tok_reg.up & BUTTON_MASK)
                    & BUTTON_MASK;
        pr_next   = bp | (~bh & held_next & BUTTON_MASK);
        rl_next   = br | (bh & ~held_next & BUTTON_MASK);

        emit = tok_reg.vld && (tok_reg.op == OP_POLL) && valid_reg
               && (tok_reg.cnt < tok_reg.limit);

        rec_o.emit     = emit;
        rec_o.last     = (CNT_W'(tok_reg.cnt + CNT_W'(1)) == tok_reg.limit) || !nxt_valid_i;
        rec_o.id       = ID_W'(SLOT_IDX + 1);
        rec_o.sx       = ax_reg;
        rec_o.sy       = ay_reg;
        rec_o.wheel    = wheel_reg;
        rec_o.held     = held_reg;
        rec_o.pressed  = pr_reg;
        rec_o.released = rl_reg;

        tok_o      = tok_reg;
        tok_o.done = tok_reg.done | act_evt;
        tok_o.cnt  = CNT_W'(tok_reg.cnt + CNT_W'(emit));
    end

    assign valid_o = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (!stall) begin
            tok_reg <= tok_i;
            if (tok_reg.vld) begin
                case (tok_reg.op)
                    OP_EVENT: begin
                        if (act_evt) begin
                            valid_reg <= 1'b1;
                            key_reg   <= tok_reg.key;
                            ax_reg    <= ax_next;
                            ay_reg    <= ay_next;
                            wheel_reg <= tok_reg.wheel;
                            held_reg  <= held_next;
                            pr_reg    <= pr_next;
                            rl_reg    <= rl_next;
                        end
                    end
                    OP_POLL: begin
                        if (valid_reg) begin
                            ax_reg    <= '0;
                            ay_reg    <= '0;
                            wheel_reg <= '0;
                            pr_reg    <= '0;
                            rl_reg    <= '0;
                        end
                    end
                    OP_CLEAR: begin
                        valid_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: hw/rtl/multi_pointer_state_table.sv
// Top level of the pointing-device state table: input decode, cell row and output register.
//
// Each accepted word of mode event, poll or clear walks the row of eight slot cells, one
// cell per cycle while no poll result waits on a full output register, and s_tready stays
// low until the word has left the last cell; an event word that is not from a pointer, or
// an unused mode, never lowers s_tready. A new device takes the first empty cell, which
// yields ids in order of first sight. Results of a poll leave in slot order through a
// one-word output register, with m_tlast on the final one.
module multi_pointer_state_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // device_key, move_x, move_y, down_bits, up_bits, wheel_present, wheel_amount.
    input  logic [mpst_pkg::S_DATA_W-1:0]    s_tdata,
    // mode, is_pointer.
    input  logic [mpst_pkg::S_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // device_id, sum_x, sum_y, wheel_value, held_bits, pressed_bits, released_bits.
    output logic [mpst_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [mpst_pkg::CNT_W-1:0]       cfg_wdata
);
    import mpst_pkg::*;

    logic [CNT_W-1:0]    cap_reg;
    logic                out_vld_reg;
    logic                out_last_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    tok_t                inj;
    tok_t                cell_tok [DEVICE_SLOTS];
    rec_t                cell_rec [DEVICE_SLOTS];
    logic [DEVICE_SLOTS-1:0] cell_valid;
    logic                busy;
    logic                emit_any;
    logic                stall;
    rec_t                rec_sel;
    mode_t               mode;
    logic                s_accept;

    assign mode     = s_tuser[1:0];
    assign s_tready = !busy;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        inj.vld   = s_accept && ((mode == MODE_POLL) || (mode == MODE_CLEAR)
                    || ((mode == MODE_EVENT) && s_tuser[2]));
        case (mode)
            MODE_POLL:  inj.op = OP_POLL;
            MODE_CLEAR: inj.op = OP_CLEAR;
            default:    inj.op = OP_EVENT;
        endcase
        inj.key   = s_tdata[31:0];
        inj.mx    = s_tdata[63:32];
        inj.my    = s_tdata[95:64];
        inj.down  = s_tdata[100:96];
        inj.up    = s_tdata[105:101];
        inj.wheel = s_tdata[106] ? s_tdata[122:107] : '0;
        inj.done  = 1'b0;
        inj.cnt   = '0;
        inj.limit = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
    end

    for (genvar i = 0; i < DEVICE_SLOTS; i++) begin : g_cell
        mpst_cell #(
            .SLOT_IDX(i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .stall      (stall),
            .tok_i      ((i == 0) ? inj : cell_tok[(i == 0) ? 0 : i-1]),
            .nxt_valid_i((i == DEVICE_SLOTS-1) ? 1'b0
                         : cell_valid[(i == DEVICE_SLOTS-1) ? i : i+1]),
            .tok_o      (cell_tok[i]),
            .valid_o    (cell_valid[i]),
            .rec_o      (cell_rec[i])
        );
    end

    always_comb begin
        busy     = 1'b0;
        emit_any = 1'b0;
        rec_sel  = '0;
        for (int i = 0; i < DEVICE_SLOTS; i++) begin
            busy     = busy | cell_tok[i].vld;
            emit_any = emit_any | cell_rec[i].emit;
            if (cell_rec[i].emit) begin
                rec_sel = rec_sel | cell_rec[i];
            end
        end
        stall = emit_any && out_vld_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (emit_any && !stall) begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= rec_sel.last;
                out_data_reg <= {5'b0, rec_sel.released, rec_sel.pressed, rec_sel.held,
                                 rec_sel.wheel, rec_sel.sy, rec_sel.sx, rec_sel.id};
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/mpst_checker.sv
// Port-level checks of the pointing-device state table and their binding to the top level.
module mpst_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mpst_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mpst_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import mpst_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_poll_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[1:0] == MODE_POLL) |=> !s_tready)
        else $error("input ready right after a poll word");

    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[1:0] == MODE_CLEAR) |=> !s_tready)
        else $error("input ready right after a clear word");

endmodule

bind multi_pointer_state_table mpst_checker u_mpst_checker (.*);
